### rtl/core/ucs_pkg.sv
// Shared types and constants for the URI component splitter.
package ucs_pkg;

    localparam int MAX_LEN = 4096;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int NKIND   = 9;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam logic [3:0] K_SCHEME = 4'd0;
    localparam logic [3:0] K_AUTH   = 4'd1;
    localparam logic [3:0] K_USER   = 4'd2;
    localparam logic [3:0] K_PASS   = 4'd3;
    localparam logic [3:0] K_HOST   = 4'd4;
    localparam logic [3:0] K_PORT   = 4'd5;
    localparam logic [3:0] K_PATH   = 4'd6;
    localparam logic [3:0] K_QUERY  = 4'd7;
    localparam logic [3:0] K_FRAG   = 4'd8;

    typedef enum logic [2:0] {
        PH_FIRST, PH_SCHEME, PH_AFTER, PH_SLASH1,
        PH_AUTH, PH_PATH, PH_QUERY, PH_FRAG
    } t_phase;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic [3:0]  component_kind;
        logic [11:0] span_start;
        logic [12:0] span_length;
        logic [15:0] port_number;
        logic        too_long;
        logic        last_span;
    } t_out;

    // one finished URI, handed from parser to emitter
    typedef struct packed {
        logic [NKIND-1:0] mask;
        logic [POS_W-1:0] sch_e;
        logic [POS_W-1:0] auth_s;
        logic [POS_W-1:0] auth_e;
        logic [POS_W-1:0] path_s;
        logic [POS_W-1:0] path_e;
        logic [POS_W-1:0] qry_s;
        logic [POS_W-1:0] qry_e;
        logic [POS_W-1:0] frag_s;
        logic [POS_W-1:0] len;
        logic             at_v;
        logic [POS_W-1:0] at_off;
        logic [POS_W-1:0] colon_off;
        logic             hc_v;
        logic [POS_W-1:0] hc_off;
        logic [15:0]      port;
        logic             ovf;
    } t_rec;

endpackage

### rtl/core/ucs_front.sv
// Byte parser: tracks phase and offsets, builds one record per URI.
module ucs_front import ucs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_data,
    output logic o_push,
    output t_rec o_rec
);

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_sch_e, n_sch_e, r_auth_s, n_auth_s, r_auth_e, n_auth_e;
    logic [POS_W-1:0] r_path_s, n_path_s, r_path_e, n_path_e;
    logic [POS_W-1:0] r_qry_s, n_qry_s, r_qry_e, n_qry_e, r_frag_s, n_frag_s;
    logic [POS_W-1:0] r_at, n_at, r_col, n_col, r_hc, n_hc;
    logic             r_at_v, n_at_v, r_col_v, n_col_v, r_hc_v, n_hc_v;
    logic [15:0]      r_port, n_port;
    logic             r_run, n_run;
    logic [NKIND-1:0] r_flags, n_flags;
    logic             r_ovf, n_ovf;

    logic [7:0]       c;
    logic [POS_W-1:0] p;
    logic             is_alpha, is_digit, do_begin, do_path;
    logic [POS_W-1:0] ps_val;
    logic [19:0]      acc10;
    logic             body, is_user, is_pass;

    assign c        = i_data.char_byte;
    assign p        = r_pos;
    assign is_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    assign is_digit = c >= 8'h30 && c <= 8'h39;
    assign acc10    = 20'(r_port) * 20'd10 + 20'(c - 8'h30);

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_sch_e = r_sch_e;
        n_auth_s = r_auth_s; n_auth_e = r_auth_e; n_path_s = r_path_s;
        n_path_e = r_path_e; n_qry_s = r_qry_s; n_qry_e = r_qry_e;
        n_frag_s = r_frag_s; n_at = r_at; n_col = r_col; n_hc = r_hc;
        n_at_v = r_at_v; n_col_v = r_col_v; n_hc_v = r_hc_v;
        n_port = r_port; n_run = r_run; n_flags = r_flags; n_ovf = r_ovf;
        do_begin = 1'b0; do_path = 1'b0; ps_val = r_path_s;
        o_push = 1'b0; o_rec = '0;
        body = 1'b0; is_user = 1'b0; is_pass = 1'b0;
        if (i_accept) begin
            if (r_pos >= POS_W'(MAX_LEN)) begin
                n_ovf = 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
                case (r_phase)
                    PH_FIRST: begin
                        if (is_alpha) n_phase = PH_SCHEME;
                        else do_begin = 1'b1;
                    end
                    PH_SCHEME: begin
                        if (c == CH_COLON) begin
                            n_sch_e = p; n_flags[K_SCHEME] = 1'b1; n_phase = PH_AFTER;
                        end else if (!(is_alpha || is_digit || c == CH_PLUS ||
                                       c == CH_MINUS || c == CH_DOT)) begin
                            do_path = 1'b1; ps_val = '0;
                        end
                    end
                    PH_AFTER: do_begin = 1'b1;
                    PH_SLASH1: begin
                        if (c == CH_SLASH) begin
                            n_auth_s = p + 1'b1; n_flags[K_AUTH] = 1'b1; n_phase = PH_AUTH;
                        end else begin
                            do_path = 1'b1; ps_val = r_path_s;
                        end
                    end
                    PH_AUTH: begin
                        if (c == CH_SLASH || c == CH_QUEST || c == CH_HASH) begin
                            n_auth_e = p; do_path = 1'b1; ps_val = p;
                        end else if (c == CH_AT && !r_at_v) begin
                            n_at_v = 1'b1; n_at = p; n_hc_v = 1'b0;
                            n_run = 1'b0; n_port = '0;
                        end else if (c == CH_COLON && !r_hc_v) begin
                            if (!r_col_v) begin
                                n_col_v = 1'b1; n_col = p;
                            end
                            n_hc_v = 1'b1; n_hc = p; n_run = 1'b1; n_port = '0;
                        end else if (c == CH_COLON && !r_col_v) begin
                            n_col_v = 1'b1; n_col = p; n_run = 1'b0;
                        end else if (r_run && is_digit) begin
                            n_port = (acc10 > 20'd65535) ? 16'hFFFF : acc10[15:0];
                        end else begin
                            n_run = 1'b0;
                        end
                    end
                    PH_QUERY: begin
                        if (c == CH_HASH) begin
                            n_qry_e = p; n_frag_s = p + 1'b1;
                            n_flags[K_FRAG] = 1'b1; n_phase = PH_FRAG;
                        end
                    end
                    default: ;
                endcase
                if (do_begin) begin
                    if (c == CH_SLASH) begin
                        n_path_s = p; n_phase = PH_SLASH1;
                    end else begin
                        do_path = 1'b1; ps_val = p;
                    end
                end
                if (do_path) begin
                    n_path_s = ps_val; n_flags[K_PATH] = 1'b1; n_phase = PH_PATH;
                end
                if (do_path || r_phase == PH_PATH) begin
                    if (c == CH_QUEST) begin
                        n_path_e = p; n_qry_s = p + 1'b1;
                        n_flags[K_QUERY] = 1'b1; n_phase = PH_QUERY;
                    end else if (c == CH_HASH) begin
                        n_path_e = p; n_frag_s = p + 1'b1;
                        n_flags[K_FRAG] = 1'b1; n_phase = PH_FRAG;
                    end
                end
            end
            if (i_data.last_char) begin
                // close the open component at the URI's end
                case (n_phase)
                    PH_SCHEME: begin
                        n_path_s = '0; n_path_e = n_pos; n_flags[K_PATH] = 1'b1;
                    end
                    PH_SLASH1: begin
                        n_path_e = n_pos; n_flags[K_PATH] = 1'b1;
                    end
                    PH_AUTH:  n_auth_e = n_pos;
                    PH_PATH:  n_path_e = n_pos;
                    PH_QUERY: n_qry_e  = n_pos;
                    default: ;
                endcase
                body    = n_flags[K_AUTH] && (n_auth_e > n_auth_s);
                is_user = body && n_at_v;
                is_pass = is_user && n_col_v && (n_col < n_at);
                o_push  = 1'b1;
                o_rec.mask = {n_flags[K_FRAG], n_flags[K_QUERY], n_flags[K_PATH],
                              body && n_hc_v, body, is_pass, is_user,
                              n_flags[K_AUTH], n_flags[K_SCHEME]};
                o_rec.sch_e = n_sch_e;   o_rec.auth_s = n_auth_s;
                o_rec.auth_e = n_auth_e; o_rec.path_s = n_path_s;
                o_rec.path_e = n_path_e; o_rec.qry_s = n_qry_s;
                o_rec.qry_e = n_qry_e;   o_rec.frag_s = n_frag_s;
                o_rec.len = n_pos;       o_rec.at_v = n_at_v;
                o_rec.at_off = n_at;     o_rec.colon_off = n_col;
                o_rec.hc_v = n_hc_v;     o_rec.hc_off = n_hc;
                o_rec.port = n_port;     o_rec.ovf = n_ovf;
                n_phase = PH_FIRST; n_pos = '0; n_sch_e = '0; n_auth_s = '0;
                n_auth_e = '0; n_path_s = '0; n_path_e = '0; n_qry_s = '0;
                n_qry_e = '0; n_frag_s = '0; n_at = '0; n_col = '0; n_hc = '0;
                n_at_v = 1'b0; n_col_v = 1'b0; n_hc_v = 1'b0; n_port = '0;
                n_run = 1'b0; n_flags = '0; n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST; r_pos <= '0; r_sch_e <= '0; r_auth_s <= '0;
            r_auth_e <= '0; r_path_s <= '0; r_path_e <= '0; r_qry_s <= '0;
            r_qry_e <= '0; r_frag_s <= '0; r_at <= '0; r_col <= '0; r_hc <= '0;
            r_at_v <= 1'b0; r_col_v <= 1'b0; r_hc_v <= 1'b0; r_port <= '0;
            r_run <= 1'b0; r_flags <= '0; r_ovf <= 1'b0;
        end else begin
            r_phase <= n_phase; r_pos <= n_pos; r_sch_e <= n_sch_e;
            r_auth_s <= n_auth_s; r_auth_e <= n_auth_e; r_path_s <= n_path_s;
            r_path_e <= n_path_e; r_qry_s <= n_qry_s; r_qry_e <= n_qry_e;
            r_frag_s <= n_frag_s; r_at <= n_at; r_col <= n_col; r_hc <= n_hc;
            r_at_v <= n_at_v; r_col_v <= n_col_v; r_hc_v <= n_hc_v;
            r_port <= n_port; r_run <= n_run; r_flags <= n_flags; r_ovf <= n_ovf;
        end
    end

endmodule

### rtl/core/ucs_queue.sv
// Two-entry record queue between parser and emitter.
module ucs_queue import ucs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_rec o_head
);

    t_rec       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

### rtl/core/ucs_back.sv
// Emitter: walks the component mask of the head record, one result per cycle while the output is not stalled.
module ucs_back import ucs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_rec i_head,
    output logic o_pop,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic [NKIND-1:0] r_done, n_done;
    logic [NKIND-1:0] rem;
    logic [3:0]       sel;
    logic             advance, single;
    logic             r_ovld, n_ovld;
    t_out             r_out, n_out;
    logic [POS_W-1:0] st, hb, he;

    assign rem     = i_head.mask & ~r_done;
    assign single  = (rem & (rem - 1'b1)) == '0;
    assign advance = !r_ovld || !i_stall;
    assign o_valid = r_ovld;
    assign o_data  = r_out;

    always_comb begin
        sel = K_FRAG;
        for (int i = NKIND - 1; i >= 0; i--) begin
            if (rem[i]) sel = 4'(i);
        end
    end

    always_comb begin
        hb = i_head.at_v ? i_head.at_off + 1'b1 : i_head.auth_s;
        he = i_head.hc_v ? i_head.hc_off : i_head.auth_e;
        n_out = r_out;
        n_out.port_number = '0;
        n_out.component_kind = sel;
        n_out.too_long = i_head.ovf;
        n_out.last_span = single;
        st = '0;
        case (sel)
            K_SCHEME: begin st = '0; n_out.span_length = i_head.sch_e; end
            K_AUTH: begin
                st = i_head.auth_s; n_out.span_length = i_head.auth_e - i_head.auth_s;
            end
            K_USER: begin
                st = i_head.auth_s;
                n_out.span_length = (i_head.mask[K_PASS] ? i_head.colon_off
                                                          : i_head.at_off) - i_head.auth_s;
            end
            K_PASS: begin
                st = i_head.colon_off + 1'b1;
                n_out.span_length = i_head.at_off - i_head.colon_off - 1'b1;
            end
            K_HOST: begin st = hb; n_out.span_length = he - hb; end
            K_PORT: begin
                st = i_head.hc_off + 1'b1;
                n_out.span_length = i_head.auth_e - i_head.hc_off - 1'b1;
                n_out.port_number = i_head.port;
            end
            K_PATH: begin
                st = i_head.path_s; n_out.span_length = i_head.path_e - i_head.path_s;
            end
            K_QUERY: begin
                st = i_head.qry_s; n_out.span_length = i_head.qry_e - i_head.qry_s;
            end
            default: begin
                st = i_head.frag_s; n_out.span_length = i_head.len - i_head.frag_s;
            end
        endcase
        n_out.span_start = st[11:0];

        n_done = r_done;
        n_ovld = r_ovld && i_stall;
        o_pop  = 1'b0;
        if (advance && i_q_valid) begin
            n_ovld = rem != '0;
            if (single) begin
                o_pop = 1'b1; n_done = '0;
            end else begin
                n_done = r_done | (NKIND'(1) << sel);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0; r_done <= '0;
        end else begin
            r_ovld <= n_ovld; r_done <= n_done;
        end
    end

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> r_out.component_kind <= K_FRAG)
        else $error("kind out of range");
    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !r_out.last_span |=> r_ovld)
        else $error("URI results cut short");
    a_kind_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !i_stall && !r_out.last_span |=>
        r_out.component_kind > $past(r_out.component_kind))
        else $error("results out of kind order");

endmodule

### rtl/core/uri_component_splitter.sv
// Top level of the URI component splitter: parser, record queue, emitter.
// Takes one byte per cycle unless stalled; a non-last byte only advances the parser.
// The last byte pushes a record into the queue; the emitter reads the head record and
// registers its results, one result per cycle while the output is not stalled.
// Input stalls only when both record queue entries are full.
// Synchronous active-low reset returns the parser to the scheme start and empties the queue.
module uri_component_splitter import ucs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic q_full, q_valid, push, pop;
    t_rec rec, head;

    assign o_stall = q_full;

    ucs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(i_valid && !q_full),
        .i_data(i_data), .o_push(push), .o_rec(rec)
    );

    ucs_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_rec(rec),
        .i_pop(pop), .o_full(q_full), .o_valid(q_valid), .o_head(head)
    );

    ucs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_head(head),
        .o_pop(pop), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

endmodule
